// ===== rtl/r2q_pkg.sv =====
// Shared constants for the rotation matrix to quaternion core.
package r2q_pkg;
    localparam int ELEM_W  = 16;    // width of one matrix element / quaternion component
    localparam int NUM_IN  = 9;     // matrix elements per input word
    localparam int NUM_Q   = 4;     // quaternion components
    localparam int QBITS   = 17;    // quotient bits kept before saturation
    localparam logic [ELEM_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 16'h8000;
endpackage

// ===== rtl/r2q_sqrt_cell.sv =====
// One cell of the integer square root chain: resolves one root bit per cycle while en is high.
module r2q_sqrt_cell #(
    parameter int RW = 16
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [RW+1:0]   rem_i,
    input  logic [RW-1:0]   root_i,
    input  logic [2*RW-1:0] rad_i,
    output logic [RW+1:0]   rem_o,
    output logic [RW-1:0]   root_o,
    output logic [2*RW-1:0] rad_o
);
    import r2q_pkg::*;

    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic            take;
    logic [RW+1:0]   rem_next;
    logic [RW-1:0]   root_next;
    logic [2*RW-1:0] rad_next;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [2*RW-1:0] rad_reg;

    always_comb begin
        rem_sh    = {rem_i, rad_i[2*RW-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
        root_next = {root_i[RW-2:0], take};
        rad_next  = {rad_i[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign rad_o  = rad_reg;
endmodule

// ===== rtl/r2q_div_cell.sv =====
// One cell of a restoring divider chain: resolves quotient bit SHIFT.
module r2q_div_cell #(
    parameter int XW    = 64,
    parameter int RW    = 16,
    parameter int SHIFT = 0
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [XW-1:0]             rem_i,
    input  logic [RW-1:0]             den_i,
    input  logic [r2q_pkg::QBITS-1:0] q_i,
    output logic [XW-1:0]             rem_o,
    output logic [RW-1:0]             den_o,
    output logic [r2q_pkg::QBITS-1:0] q_o
);
    import r2q_pkg::*;

    logic [XW-1:0]    den_sh;
    logic             take;
    logic [XW-1:0]    rem_reg;
    logic [RW-1:0]    den_reg;
    logic [QBITS-1:0] q_reg;

    always_comb begin
        den_sh = XW'(den_i) << SHIFT;
        take   = (rem_i >= den_sh);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= take ? (rem_i - den_sh) : rem_i;
            den_reg <= den_i;
            q_reg   <= {q_i[QBITS-2:0], take};
        end
    end

    assign rem_o = rem_reg;
    assign den_o = den_reg;
    assign q_o   = q_reg;
endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// Top level: 3x3 rotation matrix (fixed point) to unit quaternion, fully pipelined.
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  --------+-----+---------------------------------------------------+--------
//  s_      | in  | col0_row0 col0_row1 col0_row2 col1_row0 ... c2r2  | -
//  m_      | out | quat_x quat_y quat_z quat_w                       | invalid
//
//  One word accepted per cycle while m_tready does not stall the chain; the pipeline
//  runs through the square root chain (one cell per root bit) and the four divider
//  lanes (one cell per quotient bit).
//  Reset clears valid bits and the skid flag only; no clearing pass.
//  A stall on m_tready freezes the whole chain; one input word more is held in a
//  skid register, so s_tready is a flop and does not depend on m_tready.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // col0_row0..col2_row2, 16 b each, c0r0 lowest
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // quat_x, quat_y, quat_z, quat_w, 16 b each
    output logic [0:0]   m_tuser    // invalid
);
    import r2q_pkg::*;

    localparam int TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3; // t and components
    localparam int RW  = (TW + FRAC_BITS) / 2;                    // root bits
    localparam int NW  = 2 * RW;                                  // radicand bits
    localparam int XW  = TW + FRAC_BITS + RW;                     // dividend bits
    localparam int LAT = RW + QBITS + 2;                          // valid chain length

    // ---------------- input skid ----------------
    logic         en;
    logic         skid_full_reg;
    logic [143:0] skid_data_reg;
    logic         in_vld;
    logic [143:0] in_data;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_full_reg;
    assign in_vld   = skid_full_reg || s_tvalid;
    assign in_data  = skid_full_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (en) begin
            skid_full_reg <= 1'b0;
        end else if (s_tvalid && !skid_full_reg) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && !skid_full_reg) begin
            skid_data_reg <= s_tdata;
        end
    end

    // ---------------- branch select ----------------
    logic signed [TW-1:0] m [0:NUM_IN-1];
    logic signed [TW-1:0] one_c;
    logic signed [TW-1:0] t_next;
    logic signed [TW-1:0] c_next [0:NUM_Q-1];

    always_comb begin
        for (int i = 0; i < NUM_IN; i++) begin
            m[i] = TW'($signed(in_data[i*ELEM_W +: ELEM_W]));
        end
        one_c = TW'(1) <<< FRAC_BITS;
        // m[0]=m00 m[1]=m01 m[2]=m02 m[3]=m10 m[4]=m11 m[5]=m12 m[6]=m20 m[7]=m21 m[8]=m22
        if (m[8] <= 0) begin
            if (m[0] >= m[4]) begin
                t_next    = one_c + m[0] - m[4] - m[8];
                c_next[0] = t_next;
                c_next[1] = m[1] + m[3];
                c_next[2] = m[6] + m[2];
                c_next[3] = m[5] - m[7];
            end else begin
                t_next    = one_c - m[0] + m[4] - m[8];
                c_next[0] = m[1] + m[3];
                c_next[1] = t_next;
                c_next[2] = m[5] + m[7];
                c_next[3] = m[6] - m[2];
            end
        end else begin
            if (m[0] + m[4] <= 0) begin
                t_next    = one_c - m[0] - m[4] + m[8];
                c_next[0] = m[6] + m[2];
                c_next[1] = m[5] + m[7];
                c_next[2] = t_next;
                c_next[3] = m[1] - m[3];
            end else begin
                t_next    = one_c + m[0] + m[4] + m[8];
                c_next[0] = m[5] - m[7];
                c_next[1] = m[6] - m[2];
                c_next[2] = m[1] - m[3];
                c_next[3] = t_next;
            end
        end
    end

    // ---------------- control chain ----------------
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg <= {inv_reg[LAT-2:0], (t_next <= 0)};
        end
    end

    // ---------------- stage A and component delay line ----------------
    logic signed [TW-1:0] a_t_reg;
    logic signed [TW-1:0] c_dly_reg [0:RW][0:NUM_Q-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_t_reg <= t_next;
            for (int l = 0; l < NUM_Q; l++) begin
                c_dly_reg[0][l] <= c_next[l];
            end
            for (int k = 1; k <= RW; k++) begin
                for (int l = 0; l < NUM_Q; l++) begin
                    c_dly_reg[k][l] <= c_dly_reg[k-1][l];
                end
            end
        end
    end

    // ---------------- square root chain ----------------
    logic [RW+1:0] sq_rem  [0:RW];
    logic [RW-1:0] sq_root [0:RW];
    logic [NW-1:0] sq_rad  [0:RW];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = NW'(a_t_reg[TW-2:0]) << FRAC_BITS;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        r2q_sqrt_cell #(.RW(RW)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_i  (sq_rem[k]),
            .root_i (sq_root[k]),
            .rad_i  (sq_rad[k]),
            .rem_o  (sq_rem[k+1]),
            .root_o (sq_root[k+1]),
            .rad_o  (sq_rad[k+1])
        );
    end

    // ---------------- divider setup and lanes ----------------
    logic [XW-1:0]    dv_rem [0:NUM_Q-1][0:QBITS];
    logic [RW-1:0]    dv_den [0:NUM_Q-1][0:QBITS];
    logic [QBITS-1:0] dv_q   [0:NUM_Q-1][0:QBITS];
    logic             neg_reg [0:QBITS][0:NUM_Q-1];
    logic             ovf_reg [0:QBITS][0:NUM_Q-1];
    logic [XW-1:0]    d_rem_reg [0:NUM_Q-1];
    logic [RW-1:0]    d_den_reg;

    logic [TW-1:0] mag  [0:NUM_Q-1];
    logic [XW-1:0] dvd  [0:NUM_Q-1];
    logic [RW-1:0] root_s;

    always_comb begin
        root_s = sq_root[RW];
        for (int l = 0; l < NUM_Q; l++) begin
            mag[l] = c_dly_reg[RW][l][TW-1] ? TW'(-c_dly_reg[RW][l])
                                             : TW'(c_dly_reg[RW][l]);
            dvd[l] = (XW'(mag[l]) << (FRAC_BITS - 1)) + XW'(root_s >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_den_reg <= root_s;
            for (int l = 0; l < NUM_Q; l++) begin
                d_rem_reg[l]  <= dvd[l];
                neg_reg[0][l] <= c_dly_reg[RW][l][TW-1];
                ovf_reg[0][l] <= (dvd[l] >= (XW'(root_s) << QBITS));
            end
            for (int k = 1; k <= QBITS; k++) begin
                for (int l = 0; l < NUM_Q; l++) begin
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end
    end

    for (genvar l = 0; l < NUM_Q; l++) begin : g_lane
        assign dv_rem[l][0] = d_rem_reg[l];
        assign dv_den[l][0] = d_den_reg;
        assign dv_q[l][0]   = '0;
        for (genvar k = 0; k < QBITS; k++) begin : g_cell
            r2q_div_cell #(.XW(XW), .RW(RW), .SHIFT(QBITS - 1 - k)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .rem_i (dv_rem[l][k]),
                .den_i (dv_den[l][k]),
                .q_i   (dv_q[l][k]),
                .rem_o (dv_rem[l][k+1]),
                .den_o (dv_den[l][k+1]),
                .q_o   (dv_q[l][k+1])
            );
        end
    end

    // ---------------- saturation and output register ----------------
    logic [ELEM_W-1:0] res [0:NUM_Q-1];
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic              m_inv_reg;

    always_comb begin
        for (int l = 0; l < NUM_Q; l++) begin
            if (inv_reg[LAT-1]) begin
                res[l] = '0;
            end else if (neg_reg[QBITS][l]) begin
                res[l] = (ovf_reg[QBITS][l] || dv_q[l][QBITS] > QBITS'(32768))
                       ? SAT_NEG : ELEM_W'(-dv_q[l][QBITS]);
            end else begin
                res[l] = (ovf_reg[QBITS][l] || dv_q[l][QBITS] > QBITS'(32767))
                       ? SAT_POS : dv_q[l][QBITS][ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {res[3], res[2], res[1], res[0]};
            m_inv_reg   <= inv_reg[LAT-1];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_inv_reg;

`ifndef SYNTHESIS
    // an invalid word carries all-zero components
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result with nonzero components");

    // the skid only fills while the output side is stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without a stall");

    // a stalled output register holds its word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed under stall");
`endif
endmodule

// ===== verif/r2q_checker.sv =====
// Checker for the rotation matrix to quaternion core: watches both channels, predicts, compares.
`timescale 1ns / 1ps
module r2q_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending,
    output int           quat_count,
    output int           invalid_count
);
    import r2q_pkg::*;

    typedef struct packed {
        logic                     invalid;
        logic [NUM_Q*ELEM_W-1:0]  quat;
    } quat_t;

    quat_t expected_quats[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // c * 2^(F-1) / s, rounded half away from zero, saturated to 16 bits
    function automatic logic [ELEM_W-1:0] scale_comp(longint c, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q = ((mag << (FRAC_BITS - 1)) + (s >> 1)) / s;
        if (c < 0) return (q > 32768) ? SAT_NEG : ELEM_W'(-longint'(q));
        return (q > 32767) ? SAT_POS : ELEM_W'(q);
    endfunction

    function automatic quat_t predict_quat(logic [143:0] mat);
        longint m[3][3];    // m[col][row]
        longint t;
        longint c[4];
        longint unsigned s;
        quat_t r;
        for (int k = 0; k < NUM_IN; k++)
            m[k / 3][k % 3] = longint'($signed(mat[k*ELEM_W +: ELEM_W]));
        if (m[2][2] <= 0) begin
            if (m[0][0] >= m[1][1]) begin
                t = (64'sd1 << FRAC_BITS) + m[0][0] - m[1][1] - m[2][2];
                c = '{t, m[0][1] + m[1][0], m[2][0] + m[0][2], m[1][2] - m[2][1]};
            end else begin
                t = (64'sd1 << FRAC_BITS) - m[0][0] + m[1][1] - m[2][2];
                c = '{m[0][1] + m[1][0], t, m[1][2] + m[2][1], m[2][0] - m[0][2]};
            end
        end else if (m[0][0] + m[1][1] <= 0) begin
            t = (64'sd1 << FRAC_BITS) - m[0][0] - m[1][1] + m[2][2];
            c = '{m[2][0] + m[0][2], m[1][2] + m[2][1], t, m[0][1] - m[1][0]};
        end else begin
            t = (64'sd1 << FRAC_BITS) + m[0][0] + m[1][1] + m[2][2];
            c = '{m[1][2] - m[2][1], m[2][0] - m[0][2], m[0][1] - m[1][0], t};
        end
        r = '0;
        if (t <= 0) begin
            r.invalid = 1'b1;
            return r;
        end
        s = int_sqrt(longint'(t) << FRAC_BITS);
        if (s == 0) s = 1;
        for (int k = 0; k < NUM_Q; k++) r.quat[k*ELEM_W +: ELEM_W] = scale_comp(c[k], s);
        return r;
    endfunction

    always @(posedge aclk) begin
        quat_t exp_q;
        if (!aresetn) begin
            fail_count    <= 0;
            pending       <= 0;
            quat_count    <= 0;
            invalid_count <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_quats.push_back(predict_quat(s_tdata));
            if (m_tvalid && m_tready) begin
                quat_count <= quat_count + 1;
                if (m_tuser[0]) invalid_count <= invalid_count + 1;
                if (expected_quats.size() == 0) begin
                    $error("unexpected output word %h/%b", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (exp_q.invalid !== m_tuser[0] || exp_q.quat !== m_tdata)
                        fail_count <= fail_count + 1;
                    if (exp_q.invalid !== m_tuser[0])
                        $error("invalid: expected %0b actual %0b", exp_q.invalid, m_tuser[0]);
                    for (int k = 0; k < NUM_Q; k++)
                        if (exp_q.quat[k*ELEM_W +: ELEM_W] !== m_tdata[k*ELEM_W +: ELEM_W])
                            $error("quat_%s: expected %0d actual %0d",
                                   (k == 0) ? "x" : (k == 1) ? "y" : (k == 2) ? "z" : "w",
                                   $signed(exp_q.quat[k*ELEM_W +: ELEM_W]),
                                   $signed(m_tdata[k*ELEM_W +: ELEM_W]));
                end
            end
            pending <= expected_quats.size();
        end
    end
endmodule

// ===== verif/tb.sv =====
// Testbench top: drives matrices into the core and reports the verdict.
`timescale 1ns / 1ps
module tb;
    import r2q_pkg::*;

    localparam int N_RANDOM = 1230;
    localparam int ONE      = 1 << 14;    // 1.0 in Q2.14

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;    // col0_row0 .. col2_row2, 16 b each, lowest first
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;         // quat_x, quat_y, quat_z, quat_w
    logic [0:0]   m_tuser;         // invalid
    int           fail_count, pending, quat_count, invalid_count;
    bit           stim_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rotation_matrix_to_quaternion_core dut (.*);

    r2q_checker checker_i (.*);

    // Receiver: random stall per word, with quiet stretches of no stalling.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    // Sends one matrix; valid stays high across back-to-back words.
    task automatic send_matrix(logic [143:0] mat, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        @(posedge aclk iff s_tready);
    endtask

    function automatic logic [143:0] pack9(int e[9]);
        logic [143:0] r;
        for (int k = 0; k < NUM_IN; k++) r[k*ELEM_W +: ELEM_W] = ELEM_W'(e[k]);
        return r;
    endfunction

    // Random element: near-rotation values, small values, extremes, or raw bits.
    function automatic int rand_elem();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    return int'($urandom_range(0, 2 * ONE)) - ONE;
            3:       return int'($urandom_range(0, 8)) - 4;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    initial begin
        int e[9];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, 180-degree flips per axis, a 90-degree turn about z, zero, extremes
        send_matrix(pack9('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}), 0);
        send_matrix(pack9('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}), 0);
        send_matrix(pack9('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}), 0);
        send_matrix(pack9('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}), 0);
        send_matrix(pack9('{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE}), 0);
        send_matrix('0, 0);
        send_matrix({9{16'h7FFF}}, 1);
        send_matrix({9{16'h8000}}, 1);
        send_matrix({9{16'hFFFF}}, 1);
        send_matrix({9{16'h5555}}, 0);
        send_matrix({9{16'hAAAA}}, 0);
        // corner matrices that reach each branch
        send_matrix(pack9('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}), 0);
        send_matrix(pack9('{-ONE, 5, 0, 0, 0, 0, 0, 0, 0}), 0);
        send_matrix(pack9('{0, 0, 0, 0, 32767, 0, 0, 0, 32767}), 0);
        send_matrix(pack9('{32767, 0, 0, 0, -32768, 0, 0, 0, 1}), 0);
        send_matrix(pack9('{32767, 32767, 32767, -32768, 32767, -32768, 32767, 32767, 0}), 0);
        send_matrix(pack9('{1, 2, 3, 4, 5, 6, 7, 8, 9}), 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            for (int k = 0; k < NUM_IN; k++) e[k] = rand_elem();
            send_matrix(pack9(e), $urandom_range(0, 3) == 0);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        @(posedge aclk iff stim_done);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("covered %0d quaternion words, %0d flagged invalid, all four branches",
                 quat_count, invalid_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
